@@ rtl/keypad_calculator_with_precedence_defines.svh @@
// ----------------------------------------------------------------------------
// Keypad calculator assertion macros
// Shared wrappers for the concurrent checks of the calculator block.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CALCULATOR_WITH_PRECEDENCE_DEFINES_SVH
`define KEYPAD_CALCULATOR_WITH_PRECEDENCE_DEFINES_SVH

// same-cycle implication, reset-qualified
`define KCP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset-qualified
`define KCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/kcp_pkg.sv @@
// ----------------------------------------------------------------------------
// Keypad calculator package
// Field types, key and error codes shared by the interfaces and the core.
// ----------------------------------------------------------------------------
package kcp_pkg;

  localparam int DataW          = 32;
  localparam int ItrW           = $clog2(DataW);
  localparam int MaxOperandsDef = 10;
  localparam int CountW         = 5;

  typedef logic [1:0]              cmd_t;
  typedef logic [3:0]              digit_t;
  typedef logic [1:0]              oper_t;
  typedef logic signed [DataW-1:0] value_t;
  typedef logic [1:0]              err_t;
  typedef logic [1:0]              pend_t;

  // key commands
  localparam cmd_t CmdDigit    = 2'd0;
  localparam cmd_t CmdOperator = 2'd1;
  localparam cmd_t CmdEquals   = 2'd2;
  localparam cmd_t CmdClear    = 2'd3;

  // operator keys
  localparam oper_t OpAdd = 2'd0;
  localparam oper_t OpSub = 2'd1;
  localparam oper_t OpMul = 2'd2;
  localparam oper_t OpDiv = 2'd3;

  // error codes
  localparam err_t ErrNone    = 2'd0;
  localparam err_t ErrDivZero = 2'd1;
  localparam err_t ErrTooMany = 2'd2;

  // pending multiplicative operation
  localparam pend_t PendNone = 2'd0;
  localparam pend_t PendMul  = 2'd1;
  localparam pend_t PendDiv  = 2'd2;

endpackage

@@ rtl/kcp_cmd_if.sv @@
// ----------------------------------------------------------------------------
// Keypad command channel
// Valid/ready channel carrying one key event per word.
// ----------------------------------------------------------------------------
interface kcp_cmd_if;
  logic              valid;
  logic              ready;
  kcp_pkg::cmd_t     command;
  kcp_pkg::digit_t   digit;
  kcp_pkg::oper_t    operator;

  modport source (output valid, output command, output digit, output operator,
                  input ready);
  modport sink   (input valid, input command, input digit, input operator,
                  output ready);
endinterface

@@ rtl/kcp_res_if.sv @@
// ----------------------------------------------------------------------------
// Keypad result channel
// Valid/ready channel carrying one evaluated result per word.
// ----------------------------------------------------------------------------
interface kcp_res_if;
  logic              valid;
  logic              ready;
  kcp_pkg::value_t   value;
  kcp_pkg::err_t     error;

  modport source (output valid, output value, output error, input ready);
  modport sink   (input valid, input value, input error, output ready);
endinterface

@@ rtl/keypad_calculator_with_precedence.sv @@
// ----------------------------------------------------------------------------
// Keypad calculator with operator precedence
// Streams key words into a precedence-aware four-function evaluator.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i takes one key word (digit, operator, equals, clear) when valid and
//   ready are both high. res_o gives one word (value, error) per equals.
//   Ready on cmd_i is high only while the sequencer is idle; one key word is
//   worked on at a time.
// Work done on each key word before the next word can be taken:
//   clear                 resets the calculator state
//   digit                 bit-serial x10 + digit, one bit per cycle
//   add/sub/none pending  operand folded with no shift iteration
//   multiply pending      shift-add, one multiplier bit per cycle
//   divide pending        restoring divider, one quotient bit a cycle,
//                         plus sign fix-up before and after
//   equals                as its operand close, then the output register
// The iteration counter of the shared shift datapath paces the shift steps.
// Reset clears all calculator state and empties the output register.
// A stalled receiver holds the result in the output register; key words are
// still accepted meanwhile, and only a further equals waits for room.
// ----------------------------------------------------------------------------
`include "keypad_calculator_with_precedence_defines.svh"

module keypad_calculator_with_precedence #(
  parameter int MAX_OPERANDS = kcp_pkg::MaxOperandsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  kcp_cmd_if.sink        cmd_i,
  kcp_res_if.source      res_o
);

  localparam int DW = kcp_pkg::DataW;
  localparam int IW = kcp_pkg::ItrW;
  localparam int CW = kcp_pkg::CountW;
  localparam logic [CW:0]   MaxOps  = (CW+1)'(MAX_OPERANDS);
  localparam logic [IW-1:0] ItrLast = IW'(DW - 1);

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StDig   = 8'b0000_0010,
    StMul   = 8'b0000_0100,
    StDpre  = 8'b0000_1000,
    StDiv   = 8'b0001_0000,
    StDpost = 8'b0010_0000,
    StPost  = 8'b0100_0000,
    StEmit  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // architectural calculator state
  logic [DW-1:0]       cur_q, cur_d;      // operand being typed
  logic [DW-1:0]       prod_q, prod_d;    // open multiplicative term
  logic [DW-1:0]       sum_q, sum_d;      // finished additive terms
  kcp_pkg::pend_t      pend_q, pend_d;
  logic                sign_q, sign_d;    // 1: open term is subtracted
  logic [CW-1:0]       opcnt_q, opcnt_d;
  kcp_pkg::err_t       err_q, err_d;
  logic [IW-1:0]       itr_q, itr_d;

  // shared shift datapath
  logic [DW-1:0]       wa_q, wa_d;        // shifting operand / dividend-quotient
  logic [DW-1:0]       wb_q, wb_d;        // multiplier / divisor magnitude
  logic [DW-1:0]       wr_q, wr_d;        // accumulator / remainder / x10 result
  logic [2:0]          hist_q, hist_d;    // last three operand bits (x10)
  logic [1:0]          cy_q, cy_d;        // x10 carry, at most two
  kcp_pkg::digit_t     dg_q, dg_d;
  kcp_pkg::oper_t      op_q, op_d;
  logic                eq_q, eq_d;        // close started by equals
  logic                neg_q, neg_d;      // quotient sign

  // output register
  logic                ovld_q, ovld_d;
  logic [DW-1:0]       oval_q, oval_d;
  kcp_pkg::err_t       oerr_q, oerr_d;

  logic                cmd_acc;
  logic                start_close;
  logic                close_eq;
  logic [2:0]          dig_sum;
  logic [DW-1:0]       mul_acc;
  logic [DW:0]         div_shift;
  logic [DW:0]         div_diff;
  logic [DW-1:0]       fold_val;
  logic [CW:0]         opcnt_inc;

  assign cmd_i.ready = (state_q == StIdle);
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  assign res_o.valid = ovld_q;
  assign res_o.value = $signed(oval_q);
  assign res_o.error = oerr_q;

  // bit i of cur*10 + digit is c[i-3] + c[i-1] + d[i] + carry
  assign dig_sum   = {2'b00, hist_q[2]} + {2'b00, hist_q[0]} + {2'b00, dg_q[0]}
                   + {1'b0, cy_q};
  assign mul_acc   = wr_q + (wb_q[0] ? wa_q : '0);
  assign div_shift = {wr_q, wa_q[DW-1]};
  assign div_diff  = div_shift - {1'b0, wb_q};
  assign fold_val  = sign_q ? (sum_q - prod_q) : (sum_q + prod_q);
  assign opcnt_inc = {1'b0, opcnt_q} + (CW+1)'(1);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    pend_d      = pend_q;
    sign_d      = sign_q;
    opcnt_d     = opcnt_q;
    err_d       = err_q;
    itr_d       = itr_q;
    wa_d        = wa_q;
    wb_d        = wb_q;
    wr_d        = wr_q;
    hist_d      = hist_q;
    cy_d        = cy_q;
    dg_d        = dg_q;
    op_d        = op_q;
    eq_d        = eq_q;
    neg_d       = neg_q;
    ovld_d      = ovld_q && !res_o.ready;
    oval_d      = oval_q;
    oerr_d      = oerr_q;
    start_close = 1'b0;
    close_eq    = 1'b0;

    case (state_q)
      StIdle: begin
        if (cmd_acc) begin
          case (cmd_i.command)
            kcp_pkg::CmdClear: begin
              cur_d   = '0;
              prod_d  = '0;
              sum_d   = '0;
              pend_d  = kcp_pkg::PendNone;
              sign_d  = 1'b0;
              opcnt_d = '0;
              err_d   = kcp_pkg::ErrNone;
            end
            kcp_pkg::CmdDigit: begin
              if (err_q == kcp_pkg::ErrNone) begin
                wa_d    = cur_q;
                wr_d    = '0;
                hist_d  = '0;
                cy_d    = '0;
                dg_d    = cmd_i.digit;
                state_d = StDig;
              end
            end
            kcp_pkg::CmdOperator: begin
              if (err_q == kcp_pkg::ErrNone) begin
                op_d        = cmd_i.operator;
                eq_d        = 1'b0;
                start_close = 1'b1;
              end
            end
            default: begin
              // equals
              eq_d = 1'b1;
              if (err_q == kcp_pkg::ErrNone) begin
                start_close = 1'b1;
                close_eq    = 1'b1;
              end else begin
                state_d = StEmit;
              end
            end
          endcase
        end
      end

      StDig: begin
        wa_d   = {1'b0, wa_q[DW-1:1]};
        hist_d = {hist_q[1:0], wa_q[0]};
        dg_d   = {1'b0, dg_q[3:1]};
        cy_d   = dig_sum[2:1];
        wr_d   = {dig_sum[0], wr_q[DW-1:1]};
        itr_d  = itr_q + IW'(1);
        if (itr_q == ItrLast) begin
          cur_d   = {dig_sum[0], wr_q[DW-1:1]};
          state_d = StIdle;
        end
      end

      StMul: begin
        wr_d  = mul_acc;
        wa_d  = {wa_q[DW-2:0], 1'b0};
        wb_d  = {1'b0, wb_q[DW-1:1]};
        itr_d = itr_q + IW'(1);
        if (itr_q == ItrLast) begin
          prod_d  = mul_acc;
          state_d = StPost;
        end
      end

      StDpre: begin
        wa_d    = prod_q[DW-1] ? (DW'(0) - prod_q) : prod_q;
        wb_d    = cur_q[DW-1] ? (DW'(0) - cur_q) : cur_q;
        wr_d    = '0;
        neg_d   = prod_q[DW-1] ^ cur_q[DW-1];
        cur_d   = '0;
        state_d = StDiv;
      end

      StDiv: begin
        // restoring step: one quotient bit into the bottom of wa
        if (!div_diff[DW]) begin
          wr_d = div_diff[DW-1:0];
          wa_d = {wa_q[DW-2:0], 1'b1};
        end else begin
          wr_d = div_shift[DW-1:0];
          wa_d = {wa_q[DW-2:0], 1'b0};
        end
        itr_d = itr_q + IW'(1);
        if (itr_q == ItrLast) begin
          state_d = StDpost;
        end
      end

      StDpost: begin
        prod_d  = neg_q ? (DW'(0) - wa_q) : wa_q;
        state_d = StPost;
      end

      StPost: begin
        if (eq_q) begin
          sum_d   = fold_val;
          state_d = StEmit;
        end else if (opcnt_inc >= MaxOps) begin
          err_d   = kcp_pkg::ErrTooMany;
          state_d = StIdle;
        end else begin
          opcnt_d = opcnt_inc[CW-1:0];
          if (op_q == kcp_pkg::OpAdd || op_q == kcp_pkg::OpSub) begin
            sum_d  = fold_val;
            sign_d = (op_q == kcp_pkg::OpSub);
            pend_d = kcp_pkg::PendNone;
          end else if (op_q == kcp_pkg::OpMul) begin
            pend_d = kcp_pkg::PendMul;
          end else begin
            pend_d = kcp_pkg::PendDiv;
          end
          state_d = StIdle;
        end
      end

      StEmit: begin
        if (!ovld_q || res_o.ready) begin
          ovld_d  = 1'b1;
          oval_d  = (err_q == kcp_pkg::ErrNone) ? sum_q : '0;
          oerr_d  = err_q;
          cur_d   = '0;
          prod_d  = '0;
          sum_d   = '0;
          pend_d  = kcp_pkg::PendNone;
          sign_d  = 1'b0;
          opcnt_d = '0;
          err_d   = kcp_pkg::ErrNone;
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // operand close: fold the typed operand into the open term
    if (start_close) begin
      case (pend_q)
        kcp_pkg::PendMul: begin
          wa_d    = prod_q;
          wb_d    = cur_q;
          wr_d    = '0;
          cur_d   = '0;
          state_d = StMul;
        end
        kcp_pkg::PendDiv: begin
          if (cur_q == '0) begin
            err_d   = kcp_pkg::ErrDivZero;
            state_d = close_eq ? StEmit : StIdle;
          end else begin
            state_d = StDpre;
          end
        end
        default: begin
          prod_d  = cur_q;
          cur_d   = '0;
          state_d = StPost;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cur_q   <= '0;
      prod_q  <= '0;
      sum_q   <= '0;
      pend_q  <= kcp_pkg::PendNone;
      sign_q  <= 1'b0;
      opcnt_q <= '0;
      err_q   <= kcp_pkg::ErrNone;
      itr_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      prod_q  <= prod_d;
      sum_q   <= sum_d;
      pend_q  <= pend_d;
      sign_q  <= sign_d;
      opcnt_q <= opcnt_d;
      err_q   <= err_d;
      itr_q   <= itr_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q   <= wa_d;
    wb_q   <= wb_d;
    wr_q   <= wr_d;
    hist_q <= hist_d;
    cy_q   <= cy_d;
    dg_q   <= dg_d;
    op_q   <= op_d;
    eq_q   <= eq_d;
    neg_q  <= neg_d;
    oval_q <= oval_d;
    oerr_q <= oerr_d;
  end

  // ---- checks ----
  `KCP_ASSERT_NOW(a_err_zero_value, clk_i, rst_ni,
    res_o.valid && (res_o.error != kcp_pkg::ErrNone), res_o.value == '0,
    "error result carries a non-zero value")
  `KCP_ASSERT_NEXT(a_clear_resets, clk_i, rst_ni,
    cmd_acc && (cmd_i.command == kcp_pkg::CmdClear),
    (sum_q == '0) && (opcnt_q == '0) && (err_q == kcp_pkg::ErrNone),
    "clear left calculator state behind")
  `KCP_ASSERT_NOW(a_itr_idle, clk_i, rst_ni,
    state_q == StIdle, itr_q == '0,
    "iteration counter not at zero while idle")
  `KCP_ASSERT_NOW(a_opcnt_bound, clk_i, rst_ni,
    1'b1, {1'b0, opcnt_q} < MaxOps,
    "operand count reached the operand limit")

endmodule
